FILE: rtl/pra_pkg.sv
// ----------------------------------------------------------------------------
// pra_pkg - page range allocator shared definitions
// Request codes, result status codes and sequencer states.
// ----------------------------------------------------------------------------
package pra_pkg;

    localparam int STATUS_W = 2;

    typedef enum logic
    {
        ACT_FREE  = 1'b0,
        ACT_ALLOC = 1'b1
    } action_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_OK   = 2'd0,
        ST_OOM  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_PREP,
        S_SCAN,
        S_JOIN,
        S_APPEND,
        S_SPLIT_A,
        S_SPLIT_B,
        S_MOVE_RD,
        S_MOVE_WR
    } seq_state_t;

endpackage

FILE: rtl/page_range_allocator_unit.sv
// ----------------------------------------------------------------------------
// page_range_allocator_unit - first-fit free page range allocator
// Keeps a table of free page ranges; frees join or append (a full table
// refuses them), allocations take the first range that is large enough.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The table is walked
// one entry per cycle through a single read port of the range memory, with
// one shared adder/subtractor doing the size and end-of-range sums, and busy
// stays high until the cycle in which the result is shown. The result is
// shown for exactly one cycle with done high and must be taken then: there is
// no way to hold it off. A free into a full table is refused from S_PREP
// with status ST_FULL, before the table is walked.
module page_range_allocator_unit
    import pra_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int FRAME_BITS  = 40
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  action,
    input  logic [FRAME_BITS-1:0] start_page,
    input  logic [FRAME_BITS-1:0] run_pages,
    output logic                  done,
    output logic [FRAME_BITS-1:0] granted_page,
    output logic [STATUS_W-1:0]   status
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // range memory, start and size kept side by side
    logic [FRAME_BITS-1:0] mem_start [TABLE_DEPTH];
    logic [FRAME_BITS-1:0] mem_pages [TABLE_DEPTH];

    seq_state_t            state_reg, state_next;
    logic [CNT_W-1:0]      used_reg;
    logic [CNT_W-1:0]      scan_idx_reg;
    logic                  cmp_valid_reg;
    logic [IDX_W-1:0]      cmp_idx_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic [FRAME_BITS-1:0] hit_start_reg;
    logic [FRAME_BITS-1:0] hit_pages_reg;
    logic                  join_front_reg;
    logic                  action_reg;
    logic [FRAME_BITS-1:0] first_reg;
    logic [FRAME_BITS-1:0] count_reg;
    logic [FRAME_BITS-1:0] temp_reg;
    logic [FRAME_BITS-1:0] rd_start_reg;
    logic [FRAME_BITS-1:0] rd_pages_reg;
    logic                  done_reg;
    logic [FRAME_BITS-1:0] granted_reg;
    logic [STATUS_W-1:0]   status_reg;

    // shared adder/subtractor
    logic [FRAME_BITS-1:0] alu_a;
    logic [FRAME_BITS-1:0] alu_b;
    logic                  alu_sub;
    logic [FRAME_BITS:0]   alu_res;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [FRAME_BITS-1:0] wr_start;
    logic [FRAME_BITS-1:0] wr_pages;
    logic [IDX_W-1:0]      rd_addr;

    logic                  res_load;
    logic [FRAME_BITS-1:0] res_grant;
    status_t               res_status;

    logic                  accept;
    logic                  table_full;
    logic                  issue;
    logic                  hit_front;
    logic                  hit_back;
    logic                  scan_hit;
    logic                  alloc_exact;
    logic                  scan_miss;
    logic [IDX_W-1:0]      last_idx;

    assign accept     = start && !busy;
    assign busy       = (state_reg != S_IDLE);
    assign table_full = (used_reg == CNT_W'(TABLE_DEPTH));
    assign issue      = (scan_idx_reg < used_reg);
    assign last_idx   = IDX_W'(used_reg - CNT_W'(1));

    assign alu_res = {1'b0, alu_a} + {1'b0, alu_b ^ {FRAME_BITS{alu_sub}}}
                     + {{FRAME_BITS{1'b0}}, alu_sub};

    // compare stage of the walk
    always_comb
    begin
        hit_front   = 1'b0;
        hit_back    = 1'b0;
        alloc_exact = 1'b0;
        scan_hit    = 1'b0;
        if (action_reg == ACT_FREE)
        begin
            hit_front = cmp_valid_reg && (temp_reg == rd_start_reg);
            hit_back  = cmp_valid_reg && (alu_res[FRAME_BITS-1:0] == first_reg);
            scan_hit  = hit_front || hit_back;
        end
        else
        begin
            // carry out set means size >= request
            scan_hit    = cmp_valid_reg && alu_res[FRAME_BITS];
            alloc_exact = (alu_res[FRAME_BITS-1:0] == '0);
        end
        scan_miss = !cmp_valid_reg && !issue;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                if ((action_reg == ACT_FREE) && table_full)
                    state_next = S_IDLE;
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    if (action_reg == ACT_FREE)
                        state_next = S_JOIN;
                    else if (alloc_exact)
                        state_next = S_MOVE_RD;
                    else
                        state_next = S_SPLIT_A;
                end
                else if (scan_miss)
                begin
                    if (action_reg == ACT_FREE)
                        state_next = S_APPEND;
                    else
                        state_next = S_IDLE;
                end
            end
            S_JOIN:    state_next = S_IDLE;
            S_APPEND:  state_next = S_IDLE;
            S_SPLIT_A: state_next = S_SPLIT_B;
            S_SPLIT_B: state_next = S_IDLE;
            S_MOVE_RD: state_next = S_MOVE_WR;
            S_MOVE_WR: state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer: unit operands, memory port, result
    always_comb
    begin
        alu_a      = rd_start_reg;
        alu_b      = rd_pages_reg;
        alu_sub    = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = hit_idx_reg;
        wr_start   = hit_start_reg;
        wr_pages   = hit_pages_reg;
        rd_addr    = scan_idx_reg[IDX_W-1:0];
        res_load   = 1'b0;
        res_grant  = '0;
        res_status = ST_OK;
        case (state_reg)
            S_PREP:
            begin
                // end of the freed run
                alu_a = first_reg;
                alu_b = count_reg;
                if ((action_reg == ACT_FREE) && table_full)
                begin
                    res_load   = 1'b1;
                    res_status = ST_FULL;
                end
            end
            S_SCAN:
            begin
                if (action_reg == ACT_ALLOC)
                begin
                    alu_a   = rd_pages_reg;
                    alu_b   = count_reg;
                    alu_sub = 1'b1;
                    if (!scan_hit && scan_miss)
                    begin
                        res_load   = 1'b1;
                        res_status = ST_OOM;
                    end
                end
            end
            S_JOIN:
            begin
                alu_a    = hit_pages_reg;
                alu_b    = count_reg;
                wr_en    = 1'b1;
                wr_start = join_front_reg ? first_reg : hit_start_reg;
                wr_pages = alu_res[FRAME_BITS-1:0];
                res_load = 1'b1;
            end
            S_APPEND:
            begin
                wr_en    = 1'b1;
                wr_addr  = used_reg[IDX_W-1:0];
                wr_start = first_reg;
                wr_pages = count_reg;
                res_load = 1'b1;
            end
            S_SPLIT_A:
            begin
                alu_a   = hit_pages_reg;
                alu_b   = count_reg;
                alu_sub = 1'b1;
            end
            S_SPLIT_B:
            begin
                alu_a     = hit_start_reg;
                alu_b     = count_reg;
                wr_en     = 1'b1;
                wr_start  = alu_res[FRAME_BITS-1:0];
                wr_pages  = temp_reg;
                res_load  = 1'b1;
                res_grant = hit_start_reg;
            end
            S_MOVE_RD:
            begin
                rd_addr = last_idx;
            end
            S_MOVE_WR:
            begin
                // fill the hole with the last live entry
                wr_en     = 1'b1;
                wr_start  = rd_start_reg;
                wr_pages  = rd_pages_reg;
                res_load  = 1'b1;
                res_grant = hit_start_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_start[wr_addr] <= wr_start;
            mem_pages[wr_addr] <= wr_pages;
        end
        rd_start_reg <= mem_start[rd_addr];
        rd_pages_reg <= mem_pages[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= res_load;
            case (state_reg)
                S_PREP:
                begin
                    scan_idx_reg  <= '0;
                    cmp_valid_reg <= 1'b0;
                end
                S_SCAN:
                begin
                    // drop the read in flight once a hit is seen
                    scan_idx_reg  <= scan_idx_reg + CNT_W'(issue);
                    cmp_valid_reg <= issue && !scan_hit;
                end
                S_APPEND:  used_reg <= used_reg + CNT_W'(1);
                S_MOVE_WR: used_reg <= used_reg - CNT_W'(1);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            first_reg  <= start_page;
            count_reg  <= run_pages;
        end
        if (state_reg == S_PREP)
            temp_reg <= alu_res[FRAME_BITS-1:0];
        if (state_reg == S_SPLIT_A)
            temp_reg <= alu_res[FRAME_BITS-1:0];
        if (state_reg == S_SCAN)
            cmp_idx_reg <= scan_idx_reg[IDX_W-1:0];
        if ((state_reg == S_SCAN) && scan_hit)
        begin
            hit_idx_reg    <= cmp_idx_reg;
            hit_start_reg  <= rd_start_reg;
            hit_pages_reg  <= rd_pages_reg;
            join_front_reg <= hit_front;
        end
        if (res_load)
        begin
            granted_reg <= res_grant;
            status_reg  <= res_status;
        end
    end

    assign done         = done_reg;
    assign granted_page = granted_reg;
    assign status       = status_reg;

`ifndef SYNTH
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(TABLE_DEPTH))
        else $error("live entry count beyond table depth");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("request taken but block not busy");

    a_oom_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == ST_OOM || status_reg == ST_FULL)) |->
        (granted_reg == '0))
        else $error("failed request reports a granted page");

    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg)) |->
        (used_reg == $past(used_reg) + CNT_W'(1) ||
         used_reg == $past(used_reg) - CNT_W'(1)))
        else $error("live entry count moved by more than one");
`endif

endmodule

FILE: tb/sv/range_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_table_checker - result checker for the page range allocator
// Keeps its own copy of the free range table, works out the grant and status
// of every accepted request and compares them with each result strobe.
// ----------------------------------------------------------------------------
module range_table_checker
    import pra_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int FRAME_BITS  = 40
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic                  action,
    input  logic [FRAME_BITS-1:0] start_page,
    input  logic [FRAME_BITS-1:0] run_pages,
    input  logic                  done,
    input  logic [FRAME_BITS-1:0] granted_page,
    input  logic [STATUS_W-1:0]   status,
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed
    {
        logic [FRAME_BITS-1:0] page;
        status_t               status;
    } grant_t;

    logic [FRAME_BITS-1:0] free_base [TABLE_DEPTH];
    logic [FRAME_BITS-1:0] free_len  [TABLE_DEPTH];
    int                    live_ranges = 0;
    grant_t                grant_q [$];
    grant_t                want;
    int                    fails = 0;

    // First-fit update of the table; only live entries are ever looked at
    task automatic predict_grant(input action_t act, input logic [FRAME_BITS-1:0] first,
                                 input logic [FRAME_BITS-1:0] count, output grant_t res);
        logic [FRAME_BITS-1:0] run_end;
        logic                  hit;
        int                    last;
        res.page   = '0;
        res.status = ST_OK;
        hit        = 1'b0;
        run_end    = first + count;
        if (act == ACT_FREE)
        begin
            // a full table refuses the item before any join is tried
            if (live_ranges >= TABLE_DEPTH)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                for (int k = 0; k < live_ranges && !hit; k++)
                begin
                    if (run_end == free_base[k])
                    begin
                        free_base[k] = first;
                        free_len[k]  = free_len[k] + count;
                        hit          = 1'b1;
                    end
                    else if (first == free_base[k] + free_len[k])
                    begin
                        free_len[k] = free_len[k] + count;
                        hit         = 1'b1;
                    end
                end
                if (!hit)
                begin
                    free_base[live_ranges] = first;
                    free_len[live_ranges]  = count;
                    live_ranges++;
                end
            end
        end
        else
        begin
            for (int k = 0; k < live_ranges && !hit; k++)
            begin
                if (free_len[k] == count)
                begin
                    // exact fit: move the last live entry into the hole
                    res.page     = free_base[k];
                    last         = live_ranges - 1;
                    free_base[k] = free_base[last];
                    free_len[k]  = free_len[last];
                    live_ranges  = last;
                    hit          = 1'b1;
                end
                else if (free_len[k] > count)
                begin
                    res.page     = free_base[k];
                    free_len[k]  = free_len[k] - count;
                    free_base[k] = free_base[k] + count;
                    hit          = 1'b1;
                end
            end
            if (!hit)
                res.status = ST_OOM;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // take the result first: it belongs to an item accepted earlier
            if (done)
            begin
                if (grant_q.size() == 0)
                begin
                    $error("unexpected result: granted_page %0h status %0d",
                           granted_page, status);
                    fails++;
                end
                else
                begin
                    want = grant_q.pop_front();
                    if (granted_page !== want.page)
                    begin
                        $error("granted_page: expected %0h, actual %0h",
                               want.page, granted_page);
                        fails++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        fails++;
                    end
                end
            end
            if (start && !busy)
            begin
                predict_grant(action_t'(action), start_page, run_pages, want);
                grant_q.push_back(want);
            end
            fail_count <= fails;
            pending    <= grant_q.size();
        end
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - page range allocator testbench
// Drives directed and random free/allocate requests with random gaps,
// lets the checker compare every result, and gives the verdict.
// ----------------------------------------------------------------------------
module tb
    import pra_pkg::*;
();

    localparam int TABLE_DEPTH  = 64;
    localparam int FRAME_BITS   = 40;
    localparam int RANDOM_ITEMS = 1150;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 100;

    localparam logic [FRAME_BITS-1:0] FRAME_MAX = '1;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  start      = 1'b0;
    logic                  action     = 1'b0;
    logic [FRAME_BITS-1:0] start_page = '0;
    logic [FRAME_BITS-1:0] run_pages  = '0;
    logic                  busy;
    logic                  done;
    logic [FRAME_BITS-1:0] granted_page;
    logic [STATUS_W-1:0]   status;
    int                    fail_count;
    int                    pending;
    int                    idle_cycles = 0;
    int                    items_sent  = 0;
    bit                    no_idle     = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    page_range_allocator_unit #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FRAME_BITS  (FRAME_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .start_page   (start_page),
        .run_pages    (run_pages),
        .done         (done),
        .granted_page (granted_page),
        .status       (status)
    );

    range_table_checker #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FRAME_BITS  (FRAME_BITS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .start_page   (start_page),
        .run_pages    (run_pages),
        .done         (done),
        .granted_page (granted_page),
        .status       (status),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // Drop the run if neither an item nor a result moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [FRAME_BITS-1:0] rand_frame();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[FRAME_BITS-1:0];
    endfunction

    function automatic int next_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Called at a falling edge; returns at a falling edge once the item is taken
    task automatic send_request(input action_t act, input logic [FRAME_BITS-1:0] first,
                                input logic [FRAME_BITS-1:0] count);
        int gap;
        action     = act;
        start_page = first;
        run_pages  = count;
        start      = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
        gap = next_gap();
        if (gap > 0)
        begin
            start      = 1'b0;
            action     = 1'($urandom_range(0, 1));
            start_page = rand_frame();
            run_pages  = rand_frame();
            repeat (gap) @(negedge clk);
        end
    endtask

    initial
    begin
        int                    base_sent;
        int                    n;
        int                    r;
        int                    phase;
        logic [FRAME_BITS-1:0] first;
        logic [FRAME_BITS-1:0] count;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, zero sizes, joins at both ends, fits and wraps
        send_request(ACT_ALLOC, rand_frame(), 8);
        send_request(ACT_FREE, 0, 0);
        send_request(ACT_ALLOC, rand_frame(), 0);
        send_request(ACT_FREE, FRAME_MAX, FRAME_MAX);
        send_request(ACT_ALLOC, rand_frame(), FRAME_MAX);
        send_request(ACT_FREE, 1000, 16);
        send_request(ACT_FREE, 1016, 8);
        send_request(ACT_FREE, 992, 8);
        send_request(ACT_FREE, 2000, 8);
        send_request(ACT_FREE, 1024, 0);
        send_request(ACT_FREE, 3000, 16);
        send_request(ACT_ALLOC, rand_frame(), 0);
        send_request(ACT_ALLOC, rand_frame(), 8);
        send_request(ACT_ALLOC, rand_frame(), 24);
        send_request(ACT_ALLOC, rand_frame(), FRAME_MAX);
        send_request(ACT_ALLOC, rand_frame(), 9);
        // one range touched at both ends by the same run, size wraps to zero
        send_request(ACT_FREE, 50, FRAME_MAX - 59);
        send_request(ACT_FREE, FRAME_MAX - 9, 60);
        // run joins the first entry although it also meets the second
        send_request(ACT_FREE, 2008, 1001);
        send_request(ACT_ALLOC, rand_frame(), 1008);
        send_request(ACT_ALLOC, rand_frame(), 0);
        send_request(ACT_ALLOC, rand_frame(), 8);
        send_request(ACT_ALLOC, rand_frame(), 0);
        send_request(ACT_FREE, FRAME_MAX - 3, 16);
        send_request(ACT_ALLOC, rand_frame(), 8);
        send_request(ACT_ALLOC, rand_frame(), 8);

        base_sent = items_sent;
        while (items_sent - base_sent < RANDOM_ITEMS)
        begin
            phase   = $urandom_range(0, 99);
            no_idle = ($urandom_range(0, 3) == 0);
            if (phase < 30)
            begin
                // fill: scattered frees, enough to hit a full table
                n = $urandom_range(40, 80);
                repeat (n)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 15)
                        first = FRAME_BITS'(8 * $urandom_range(0, 511));
                    else
                        first = rand_frame();
                    if (r >= 90)
                        count = FRAME_BITS'(8 * $urandom_range(1, 4));
                    else
                        count = 8;
                    send_request(ACT_FREE, first, count);
                end
            end
            else if (phase < 55)
            begin
                // drain: mostly small allocations that empty ranges one by one
                n = $urandom_range(30, 80);
                repeat (n)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 85)
                        count = 8;
                    else if (r < 90)
                        count = 0;
                    else if (r < 95)
                        count = FRAME_BITS'(8 * $urandom_range(1, 8));
                    else
                        count = rand_frame();
                    send_request(ACT_ALLOC, rand_frame(), count);
                end
            end
            else
            begin
                // mixed traffic on a small grid so that joins are common
                n = $urandom_range(20, 60);
                repeat (n)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 53)
                        send_request(ACT_FREE, FRAME_BITS'(8 * $urandom_range(0, 511)),
                                     FRAME_BITS'(8 * $urandom_range(1, 8)));
                    else if (r < 55)
                        send_request(ACT_FREE, FRAME_BITS'(8 * $urandom_range(0, 511)), 0);
                    else if (r < 88)
                        send_request(ACT_ALLOC, rand_frame(),
                                     FRAME_BITS'(8 * $urandom_range(0, 8)));
                    else if (r < 94)
                        send_request(ACT_ALLOC, rand_frame(), rand_frame());
                    else
                        send_request(ACT_FREE, rand_frame(), 8);
                end
            end
        end

        start = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
